@@ hdl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the priority task table
// request and response structs, table entry layout, codes and sequencer state
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int TASK_SLOTS_DEF = 64;

  localparam int ID_W   = 16;
  localparam int USER_W = 16;
  localparam int PRIO_W = 31;

  // command codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_EDIT   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_EXEC   = 2'd3;

  // response status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   task_id;
    logic [USER_W-1:0] user_id;
    logic [PRIO_W-1:0] priority_req;
  } ptt_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [USER_W-1:0] owner;
  } ptt_rsp_t;

  // one table slot as stored in the ram
  typedef struct packed {
    logic              live;
    logic [ID_W-1:0]   task_id;
    logic [USER_W-1:0] user_id;
    logic [PRIO_W-1:0] prio;
  } ptt_entry_t;

  localparam int ENTRY_W = $bits(ptt_entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } ptt_state_t;

  // sequencer controls toward the datapath
  typedef struct packed {
    logic idle;
    logic clr_wr;
    logic rd_en;
    logic commit;
    logic resp_load;
  } ptt_ctl_t;

  // scan unit hit flags
  typedef struct packed {
    logic match_hit;
    logic free_hit;
    logic best_hit;
  } ptt_hits_t;

endpackage

@@ hdl/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// ptt_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/ptt_scan.sv @@
// ----------------------------------------------------------------------------
// ptt_scan: shared compare unit of the priority task table
// looks at one slot per cycle: id match, first free slot, running maximum
// ----------------------------------------------------------------------------
module ptt_scan
  import ptt_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          sample,
  input  logic [$clog2(TASK_SLOTS)-1:0] idx,
  input  ptt_entry_t                    entry,
  input  logic [ID_W-1:0]               key,
  output ptt_hits_t                     hits,
  output logic [$clog2(TASK_SLOTS)-1:0] match_idx,
  output logic [USER_W-1:0]             match_user,
  output logic [$clog2(TASK_SLOTS)-1:0] free_idx,
  output logic [$clog2(TASK_SLOTS)-1:0] best_idx,
  output logic [USER_W-1:0]             best_user
);

  localparam int AW = $clog2(TASK_SLOTS);

  ptt_hits_t           hits_r, hits_nxt;
  logic [AW-1:0]       match_idx_r, match_idx_nxt;
  logic [USER_W-1:0]   match_user_r, match_user_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  logic [USER_W-1:0]   best_user_r, best_user_nxt;
  logic [PRIO_W+ID_W-1:0] best_key_r, best_key_nxt;
  logic                is_better;

  // priority first, larger task id breaks ties
  assign is_better = ({entry.prio, entry.task_id} > best_key_r);

  always_comb begin
    hits_nxt       = hits_r;
    match_idx_nxt  = match_idx_r;
    match_user_nxt = match_user_r;
    free_idx_nxt   = free_idx_r;
    best_idx_nxt   = best_idx_r;
    best_user_nxt  = best_user_r;
    best_key_nxt   = best_key_r;
    if (start) begin
      hits_nxt = '0;
    end else if (sample) begin
      if (entry.live && (entry.task_id == key) && !hits_r.match_hit) begin
        hits_nxt.match_hit = 1'b1;
        match_idx_nxt      = idx;
        match_user_nxt     = entry.user_id;
      end
      if (!entry.live && !hits_r.free_hit) begin
        hits_nxt.free_hit = 1'b1;
        free_idx_nxt      = idx;
      end
      if (entry.live && (!hits_r.best_hit || is_better)) begin
        hits_nxt.best_hit = 1'b1;
        best_idx_nxt      = idx;
        best_user_nxt     = entry.user_id;
        best_key_nxt      = {entry.prio, entry.task_id};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0;
    end else begin
      hits_r <= hits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r  <= match_idx_nxt;
    match_user_r <= match_user_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_user_r  <= best_user_nxt;
    best_key_r   <= best_key_nxt;
  end

  assign hits       = hits_r;
  assign match_idx  = match_idx_r;
  assign match_user = match_user_r;
  assign free_idx   = free_idx_r;
  assign best_idx   = best_idx_r;
  assign best_user  = best_user_r;

endmodule

@@ hdl/ptt_seq.sv @@
// ----------------------------------------------------------------------------
// ptt_seq: sequencer of the priority task table
// clearing pass after reset, slot scan, commit and response hand-off
// ----------------------------------------------------------------------------
module ptt_seq
  import ptt_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          out_free,
  output ptt_ctl_t                      ctl,
  output logic [$clog2(TASK_SLOTS)-1:0] addr,
  output logic                          sample,
  output logic [$clog2(TASK_SLOTS)-1:0] sample_idx
);

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(TASK_SLOTS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TASK_SLOTS);

  ptt_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if ((cnt_r == CNT_END) && !rd_vld_r) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // slot counter
  always_comb begin
    cnt_nxt = '0;
    if ((state_r == ST_CLEAR) && (cnt_r != CNT_LAST)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (state_r == ST_SCAN) begin
      cnt_nxt = (cnt_r == CNT_END) ? cnt_r : cnt_r + 1'b1;
    end
  end

  // outputs
  always_comb begin
    ctl           = '0;
    ctl.idle      = (state_r == ST_IDLE);
    ctl.clr_wr    = (state_r == ST_CLEAR);
    ctl.rd_en     = (state_r == ST_SCAN) && (cnt_r != CNT_END);
    ctl.commit    = (state_r == ST_COMMIT);
    ctl.resp_load = (state_r == ST_RESP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[AW-1:0];
  end

  assign addr       = cnt_r[AW-1:0];
  assign sample     = rd_vld_r;
  assign sample_idx = rd_idx_r;

endmodule

@@ hdl/priority_task_table_top.sv @@
// ----------------------------------------------------------------------------
// priority_task_table_top: table of live tasks with max-priority execute
// requests: one at a time, accepted only while idle; each runs a slot scan
//   that reads the single table ram read port one slot per cycle
// reset: rst_n synchronous active low; a clearing pass then marks
//   every slot free, no request is accepted meanwhile
// ----------------------------------------------------------------------------
module priority_task_table_top
  import ptt_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ptt_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ptt_rsp_t out_data
);

  localparam int AW = $clog2(TASK_SLOTS);

  ptt_ctl_t      ctl;
  logic [AW-1:0] seq_addr;
  logic          sample;
  logic [AW-1:0] sample_idx;
  logic          accept;
  logic          out_free;

  // latched request, held for the whole scan
  ptt_req_t      req_r;

  // table ram
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ptt_entry_t    wr_data;
  ptt_entry_t    rd_data;

  // scan results
  ptt_hits_t         hits;
  logic [AW-1:0]     match_idx;
  logic [USER_W-1:0] match_user;
  logic [AW-1:0]     free_idx;
  logic [AW-1:0]     best_idx;
  logic [USER_W-1:0] best_user;

  // commit decision
  logic          cm_write;
  logic [AW-1:0] cm_idx;
  ptt_entry_t    cm_entry;
  ptt_rsp_t      cm_rsp;

  ptt_rsp_t      rsp_r;
  logic          out_valid_r;
  ptt_rsp_t      out_data_r;

  // requests are taken only while the sequencer sits idle
  assign in_stall = !ctl.idle;
  assign accept   = in_valid && ctl.idle;
  assign out_free = !out_valid_r || !out_stall;

  ptt_seq #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .out_free   (out_free),
    .ctl        (ctl),
    .addr       (seq_addr),
    .sample     (sample),
    .sample_idx (sample_idx)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  // clearing pass writes free slots, commit writes the chosen slot
  assign wr_en   = ctl.clr_wr || (ctl.commit && cm_write);
  assign wr_addr = ctl.clr_wr ? seq_addr : cm_idx;
  assign wr_data = ctl.clr_wr ? ptt_entry_t'('0) : cm_entry;

  ptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (seq_addr),
    .rd_data (rd_data)
  );

  // one slot per cycle through the shared compare unit
  ptt_scan #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .sample     (sample),
    .idx        (sample_idx),
    .entry      (rd_data),
    .key        (req_r.task_id),
    .hits       (hits),
    .match_idx  (match_idx),
    .match_user (match_user),
    .free_idx   (free_idx),
    .best_idx   (best_idx),
    .best_user  (best_user)
  );

  // decide the table update and the response once the scan is done
  always_comb begin
    cm_write = 1'b0;
    cm_idx   = match_idx;
    cm_entry = '0;
    cm_rsp   = '0;
    unique case (req_r.action)
      ACT_ADD: begin
        // an existing id keeps its slot, a new one takes the lowest free slot
        cm_entry = '{live: 1'b1, task_id: req_r.task_id, user_id: req_r.user_id,
                     prio: req_r.priority_req};
        if (hits.match_hit) begin
          cm_write = 1'b1;
        end else if (hits.free_hit) begin
          cm_write = 1'b1;
          cm_idx   = free_idx;
        end else begin
          cm_rsp.status = STAT_FULL;
        end
      end
      ACT_EDIT: begin
        cm_entry = '{live: 1'b1, task_id: req_r.task_id, user_id: match_user,
                     prio: req_r.priority_req};
        if (hits.match_hit) begin
          cm_write = 1'b1;
        end else begin
          cm_rsp.status = STAT_UNKNOWN;
        end
      end
      ACT_REMOVE: begin
        // a cleared live bit frees the slot
        if (hits.match_hit) begin
          cm_write = 1'b1;
        end else begin
          cm_rsp.status = STAT_UNKNOWN;
        end
      end
      ACT_EXEC: begin
        cm_idx = best_idx;
        if (hits.best_hit) begin
          cm_write     = 1'b1;
          cm_rsp.owner = best_user;
        end else begin
          cm_rsp.status = STAT_EMPTY;
        end
      end
      default: begin
        cm_write = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp_r <= cm_rsp;
    end
  end

  // output register, loaded when free or being drained this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resp_load) begin
      out_data_r <= rsp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
